/* sv/ndt_pkg.sv */
// Package for the note duration tracker: table geometry, transaction
// structs, event codes and the length saturation helper.
// No dependencies.
`default_nettype none

package ndt_pkg;

  localparam int MAX_NOTES = 16;
  localparam int TICK_BITS = 16;

  localparam int LEN_W  = 16;
  localparam int CNT_W  = $clog2(MAX_NOTES + 1);
  localparam int SAT_W  = (TICK_BITS > LEN_W) ? TICK_BITS : LEN_W;

  localparam logic       OP_START    = 1'b0;
  localparam logic       OP_TICK     = 1'b1;
  localparam logic       EV_KEY_ON   = 1'b0;
  localparam logic       EV_KEY_OFF  = 1'b1;
  localparam logic [7:0] KEY_OFF_VEL = 8'hDD;

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  typedef struct packed {
    logic             op;
    logic [6:0]       note_number;
    logic [LEN_W-1:0] length_ticks;
    logic [3:0]       channel;
    logic [6:0]       velocity;
  } ndt_in_t;

  typedef struct packed {
    logic       event_kind;
    logic [3:0] out_channel;
    logic [6:0] out_note;
    logic [7:0] out_velocity;
    logic       untracked;
    logic       last;
  } ndt_out_t;

  typedef struct packed {
    logic                 valid;
    logic [6:0]           note;
    logic [3:0]           channel;
    logic [TICK_BITS-1:0] remaining;
  } ndt_entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic take_head;
  } ndt_cell_ctrl_t;

  // A zero length becomes one tick; a length beyond the counter range saturates.
  function automatic logic [TICK_BITS-1:0] sat_len(input logic [LEN_W-1:0] len);
    logic [SAT_W-1:0] len_ext;
    logic [SAT_W-1:0] max_ext;
    len_ext = SAT_W'(len);
    max_ext = SAT_W'(TICK_MAX);
    if (len_ext == '0) begin
      sat_len = TICK_BITS'(1);
    end else if (len_ext > max_ext) begin
      sat_len = TICK_MAX;
    end else begin
      sat_len = TICK_BITS'(len_ext);
    end
  endfunction

endpackage

`default_nettype wire

/* sv/ndt_cell.sv */
// One slot of the note table chain: holds an entry and takes its next value
// from the right-hand neighbour, the recirculated head or a new note.
// Depends on ndt_pkg.
`default_nettype none

module ndt_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ndt_pkg::ndt_cell_ctrl_t ctrl,
  input  wire ndt_pkg::ndt_entry_t    new_entry,
  input  wire ndt_pkg::ndt_entry_t    head_entry,
  input  wire ndt_pkg::ndt_entry_t    right_entry,
  output ndt_pkg::ndt_entry_t         entry
);
  import ndt_pkg::*;

  ndt_entry_t entry_r;
  ndt_entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load) begin
      entry_nxt = new_entry;
    end else if (ctrl.shift) begin
      entry_nxt = ctrl.take_head ? head_entry : right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r.note      <= entry_nxt.note;
    entry_r.channel   <= entry_nxt.channel;
    entry_r.remaining <= entry_nxt.remaining;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

/* sv/note_duration_tracker.sv */
// Top level of the note duration tracker: a chain of table cells, the tick
// scan sequencer and the event output register.
// Depends on ndt_pkg and ndt_cell.
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_ready   ndt_in_t  (start note or tick)
// out_      output     out_valid/out_ready ndt_out_t (key-on / key-off event)
//
// A start transaction loads its key-on straight into the output register. A
// tick scans the stored notes through the head cell, one per cycle unless an
// expiry must push a held key-off while the output has no room, holding each
// expiry back a step so the final key-off carries the last flag; that final
// key-off is sent from the flush state after the scan. Input is taken only when
// idle with a free output register; reset empties the table at once.

module note_duration_tracker (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ndt_pkg::ndt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ndt_pkg::ndt_out_t     out_data
);
  import ndt_pkg::*;

  // Sequencer states: idle, scanning the table for a tick, and sending the
  // final held key-off.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;       // stored notes, packed at the low cells
  logic [CNT_W-1:0] left_r, left_nxt;     // entries still to visit in the scan
  logic             pend_v_r, pend_v_nxt; // key-off waiting to learn whether it is last
  logic [6:0]       pend_note_r, pend_note_nxt;
  logic [3:0]       pend_chan_r, pend_chan_nxt;
  logic             out_valid_r, out_valid_nxt;
  ndt_out_t         out_data_r, out_data_nxt;

  ndt_entry_t       cells [MAX_NOTES];
  ndt_entry_t       rights [MAX_NOTES];
  ndt_cell_ctrl_t   ctrls [MAX_NOTES];
  ndt_entry_t       new_entry;
  ndt_entry_t       survivor;
  ndt_entry_t       head;

  logic out_free;
  logic accept;
  logic do_start;
  logic do_tick;
  logic full;
  logic head_exp;
  logic adv;
  logic push_pend;
  logic flush;

  // The output register is free when empty or when its event leaves now.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign do_start = accept && (in_data.op == OP_START) && (in_data.note_number != 7'd0);
  assign do_tick  = accept && (in_data.op == OP_TICK) && (cnt_r != '0);
  assign full     = (cnt_r == CNT_W'(MAX_NOTES));

  // The head cell is always the next entry to visit during a scan.
  assign head     = cells[0];
  assign head_exp = (head.remaining == TICK_BITS'(1));

  // A step that would push a held key-off waits for room in the output.
  assign adv       = (state_r == ST_SCAN) && (!head_exp || !pend_v_r || out_free);
  assign push_pend = adv && head_exp && pend_v_r;
  assign flush     = (state_r == ST_FLUSH) && out_free;

  always_comb begin
    new_entry.valid     = 1'b1;
    new_entry.note      = in_data.note_number;
    new_entry.channel   = in_data.channel;
    new_entry.remaining = sat_len(in_data.length_ticks);
    survivor            = head;
    survivor.remaining  = head.remaining - TICK_BITS'(1);
  end

  // The chain shifts towards the head on every scan step. A surviving head
  // re-enters at the top of the occupied region, so the region rotates in
  // start order; an expiring head simply drops out and the region shrinks.
  for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
    if (i == MAX_NOTES - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_mid
      assign rights[i] = cells[i + 1];
    end

    assign ctrls[i].load      = do_start && !full && (cnt_r == CNT_W'(i));
    assign ctrls[i].shift     = adv;
    assign ctrls[i].take_head = !head_exp && (cnt_r == CNT_W'(i + 1));

    ndt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrls[i]),
      .new_entry   (new_entry),
      .head_entry  (survivor),
      .right_entry (rights[i]),
      .entry       (cells[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    pend_v_nxt    = pend_v_r;
    pend_note_nxt = pend_note_r;
    pend_chan_nxt = pend_chan_r;

    case (state_r)
      ST_IDLE: begin
        if (do_start && !full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (do_tick) begin
          left_nxt  = cnt_r;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          left_nxt = left_r - CNT_W'(1);
          if (head_exp) begin
            cnt_nxt       = cnt_r - CNT_W'(1);
            pend_v_nxt    = 1'b1;
            pend_note_nxt = head.note;
            pend_chan_nxt = head.channel;
          end
          if (left_r == CNT_W'(1)) begin
            state_nxt = (pend_v_r || head_exp) ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (flush) begin
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Event output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (do_start) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.event_kind   = EV_KEY_ON;
      out_data_nxt.out_channel  = in_data.channel;
      out_data_nxt.out_note     = in_data.note_number;
      out_data_nxt.out_velocity = {1'b0, in_data.velocity};
      out_data_nxt.untracked    = full;
      out_data_nxt.last         = 1'b1;
    end else if (push_pend || flush) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.event_kind   = EV_KEY_OFF;
      out_data_nxt.out_channel  = pend_chan_r;
      out_data_nxt.out_note     = pend_note_r;
      out_data_nxt.out_velocity = KEY_OFF_VEL;
      out_data_nxt.untracked    = 1'b0;
      out_data_nxt.last         = flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      left_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_note_r <= pend_note_nxt;
    pend_chan_r <= pend_chan_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* dv/tb_note_duration_tracker.sv */
// Self-checking testbench for note_duration_tracker: a scoreboard class that
// predicts key-on and key-off events, plus tasks that drive the block.
// Depends on ndt_pkg and the note_duration_tracker RTL.

// Scoreboard: keeps its own copy of the note table, works out the events that
// each accepted input transaction must cause and checks the events that come out.
class note_event_scoreboard;
  ndt_pkg::ndt_out_t                  pending_events[$];
  logic                               slot_used [ndt_pkg::MAX_NOTES];
  logic [6:0]                         slot_note [ndt_pkg::MAX_NOTES];
  logic [3:0]                         slot_chan [ndt_pkg::MAX_NOTES];
  logic [ndt_pkg::TICK_BITS-1:0]      slot_left [ndt_pkg::MAX_NOTES];
  int mismatches;
  int starts_seen;
  int untracked_starts;
  int ticks_seen;
  int key_ons_checked;
  int key_offs_checked;

  function new();
    for (int i = 0; i < ndt_pkg::MAX_NOTES; i++) begin
      slot_used[i] = 1'b0;
      slot_note[i] = '0;
      slot_chan[i] = '0;
      slot_left[i] = '0;
    end
    mismatches       = 0;
    starts_seen      = 0;
    untracked_starts = 0;
    ticks_seen       = 0;
    key_ons_checked  = 0;
    key_offs_checked = 0;
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function int stored_notes();
    int n;
    n = 0;
    for (int i = 0; i < ndt_pkg::MAX_NOTES; i++) begin
      if (slot_used[i]) n++;
    end
    return n;
  endfunction

  // Zero is stored as one tick; anything past the counter range saturates.
  function logic [ndt_pkg::TICK_BITS-1:0] clamp_length(logic [ndt_pkg::LEN_W-1:0] len);
    longint unsigned wide;
    longint unsigned top;
    wide = longint'(len);
    top  = longint'(ndt_pkg::TICK_MAX);
    if (wide == 0) begin
      return ndt_pkg::TICK_BITS'(1);
    end else if (wide > top) begin
      return ndt_pkg::TICK_MAX;
    end
    return ndt_pkg::TICK_BITS'(wide);
  endfunction

  function void note_input(ndt_pkg::ndt_in_t item);
    ndt_pkg::ndt_out_t ev;
    ndt_pkg::ndt_out_t held;
    bit                have_held;
    int                slot;
    int                kept;
    logic [ndt_pkg::TICK_BITS-1:0] left;
    if (item.op == ndt_pkg::OP_START) begin
      if (item.note_number == 7'd0) return;
      starts_seen++;
      slot = -1;
      for (int i = 0; i < ndt_pkg::MAX_NOTES; i++) begin
        if (!slot_used[i] && slot < 0) slot = i;
      end
      ev.event_kind   = ndt_pkg::EV_KEY_ON;
      ev.out_channel  = item.channel;
      ev.out_note     = item.note_number;
      ev.out_velocity = {1'b0, item.velocity};
      ev.untracked    = (slot < 0);
      ev.last         = 1'b1;
      pending_events.insert(pending_events.size(), ev);
      if (slot < 0) begin
        untracked_starts++;
      end else begin
        slot_used[slot] = 1'b1;
        slot_note[slot] = item.note_number;
        slot_chan[slot] = item.channel;
        slot_left[slot] = clamp_length(item.length_ticks);
      end
    end else begin
      ticks_seen++;
      kept      = 0;
      have_held = 1'b0;
      for (int i = 0; i < ndt_pkg::MAX_NOTES; i++) begin
        if (slot_used[i]) begin
          left = slot_left[i] - 1'b1;
          if (left == '0) begin
            // The previous expiry is not the final one of this tick.
            if (have_held) pending_events.insert(pending_events.size(), held);
            held.event_kind   = ndt_pkg::EV_KEY_OFF;
            held.out_channel  = slot_chan[i];
            held.out_note     = slot_note[i];
            held.out_velocity = ndt_pkg::KEY_OFF_VEL;
            held.untracked    = 1'b0;
            held.last         = 1'b0;
            have_held         = 1'b1;
          end else begin
            slot_used[kept] = 1'b1;
            slot_note[kept] = slot_note[i];
            slot_chan[kept] = slot_chan[i];
            slot_left[kept] = left;
            kept++;
          end
        end
      end
      for (int i = kept; i < ndt_pkg::MAX_NOTES; i++) slot_used[i] = 1'b0;
      if (have_held) begin
        held.last = 1'b1;
        pending_events.insert(pending_events.size(), held);
      end
    end
  endfunction

  task compare_field(string field, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
    end
  endtask

  task check_result(ndt_pkg::ndt_out_t got);
    ndt_pkg::ndt_out_t want;
    if (pending_events.size() == 0) begin
      report($sformatf("event 0x%0h arrived with nothing expected", got));
      return;
    end
    want = pending_events.pop_front();
    compare_field("event_kind", 8'(got.event_kind), 8'(want.event_kind));
    compare_field("out_channel", 8'(got.out_channel), 8'(want.out_channel));
    compare_field("out_note", 8'(got.out_note), 8'(want.out_note));
    compare_field("out_velocity", got.out_velocity, want.out_velocity);
    compare_field("untracked", 8'(got.untracked), 8'(want.untracked));
    compare_field("last", 8'(got.last), 8'(want.last));
    if (want.event_kind == ndt_pkg::EV_KEY_ON) key_ons_checked++;
    else key_offs_checked++;
  endtask
endclass

module tb_note_duration_tracker;

  // Items per random phase and the size of the burst sent while the
  // receiver is held off.
  localparam int PHASE_ITEMS  = 108;
  localparam int BURST_ITEMS  = 24;
  localparam int HOLD_CYCLES  = 300;
  // The limit leaves a wide margin on top of the slowest correct run.
  localparam int CYCLE_LIMIT  = 400000;
  // A tick may scan the whole table, so this many quiet cycles after the
  // last expected event show up any stray event.
  localparam int DRAIN_CYCLES = 4 * ndt_pkg::MAX_NOTES + 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ndt_pkg::ndt_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ndt_pkg::ndt_out_t out_data;

  note_event_scoreboard sb;

  // Idle rates in percent, set by the main sequence for each phase.
  int send_idle = 0;
  int recv_idle = 0;

  // The main sequence asks for a hold-off by bumping hold_requests; the
  // receiver process notices the change and counts the stretch itself.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int cycle_count   = 0;

  note_duration_tracker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake must not keep the run going for ever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  // Everything is sampled at the edge, so the values seen are those the
  // block saw when it decided on the transaction.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Output monitor: every accepted event transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Offers one input transaction, with random idle cycles in front of it,
  // and returns at the edge at which the block accepts it.  Valid is only
  // assigned once per edge, so back-to-back transactions keep it high.
  task automatic send_item(input ndt_pkg::ndt_in_t item);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  function automatic ndt_pkg::ndt_in_t make_item(logic op, logic [6:0] note,
                                                 logic [15:0] len, logic [3:0] chan,
                                                 logic [6:0] vel);
    ndt_pkg::ndt_in_t item;
    item.op           = op;
    item.note_number  = note;
    item.length_ticks = len;
    item.channel      = chan;
    item.velocity     = vel;
    return item;
  endfunction

  // A transaction of the given op with a fully random payload; a start's note may be zero.
  function automatic ndt_pkg::ndt_in_t noise_item(logic op);
    return make_item(op, 7'($urandom), 16'($urandom), 4'($urandom), 7'($urandom));
  endfunction

  // Mostly well-formed traffic: short notes and ticks so that notes pile up
  // and expire together.  A start that meets a full table carries a full
  // width length, since it will never be stored anyway.
  function automatic ndt_pkg::ndt_in_t random_item(int stored);
    int          pick;
    int          len_pick;
    logic [15:0] len;
    pick = $urandom_range(99);
    if (pick < 40) return noise_item(ndt_pkg::OP_TICK);
    if (pick < 48) return noise_item(ndt_pkg::OP_START);
    len_pick = $urandom_range(99);
    if (stored >= ndt_pkg::MAX_NOTES) len = 16'($urandom);
    else if (len_pick < 10) len = 16'd0;
    else if (len_pick < 80) len = 16'($urandom_range(6, 1));
    else len = 16'($urandom_range(30, 7));
    return make_item(ndt_pkg::OP_START, 7'($urandom_range(127, 1)), len,
                     4'($urandom), 7'($urandom));
  endfunction

  task automatic run_random(input int count);
    ndt_pkg::ndt_in_t item;
    int               done;
    done = 0;
    while (done < count) begin
      item = random_item(sb.stored_notes());
      send_item(item);
      // Starts with note zero are ignored by the block and do not count.
      if (item.op == ndt_pkg::OP_TICK || item.note_number != 7'd0) done++;
    end
  endtask

  initial begin
    sb = new();

    // Synchronous reset, released at an edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the first phase's idle rates.
    send_idle = 38;
    recv_idle = 45;
    // A tick on an empty table, then a start with note zero; neither
    // yields an event.
    send_item(make_item(ndt_pkg::OP_TICK, 7'h7F, 16'hFFFF, 4'hF, 7'h7F));
    send_item(make_item(ndt_pkg::OP_START, 7'd0, 16'hFFFF, 4'hF, 7'h7F));
    // A zero length note must expire on the very next tick.
    send_item(make_item(ndt_pkg::OP_START, 7'd127, 16'd0, 4'hF, 7'h7F));
    send_item(make_item(ndt_pkg::OP_TICK, 7'd0, 16'd0, 4'h0, 7'h0));
    // A tick that finds a stored note but releases nothing.
    send_item(make_item(ndt_pkg::OP_START, 7'd64, 16'd2, 4'd5, 7'd64));
    send_item(make_item(ndt_pkg::OP_TICK, 7'h55, 16'h5555, 4'h5, 7'h55));
    // Fill the table, with the field extremes among the notes.
    for (int i = 0; i < ndt_pkg::MAX_NOTES - 1; i++) begin
      send_item(make_item(ndt_pkg::OP_START, (i == 0) ? 7'd1 : 7'(8 * i),
                          (i % 2 == 0) ? 16'd1 : 16'd2, 4'(i),
                          (i == 0) ? 7'd0 : 7'(127 - i)));
    end
    // Full table: the key-on still comes out, marked as untracked.  The
    // longest length goes here as such a note is never stored.
    send_item(make_item(ndt_pkg::OP_START, 7'd100, 16'hFFFF, 4'd10, 7'd33));
    // Two ticks that release the whole table in two large groups.
    send_item(make_item(ndt_pkg::OP_TICK, 7'h2A, 16'hAAAA, 4'hA, 7'h2A));
    send_item(make_item(ndt_pkg::OP_TICK, 7'h7F, 16'hFFFF, 4'hF, 7'h7F));

    // Random phase with the sender idling less than the receiver.
    run_random(PHASE_ITEMS);

    // The other way round.
    send_idle = 45;
    recv_idle = 38;
    run_random(PHASE_ITEMS);

    // No idling at all.  It opens with a long receiver hold-off while a
    // burst of starts is offered, so the output backs up and the block has
    // to refuse input; the burst also overfills the table.
    send_idle = 0;
    recv_idle = 0;
    hold_requests = hold_requests + 1;
    for (int i = 0; i < BURST_ITEMS; i++) begin
      send_item(make_item(ndt_pkg::OP_START, 7'($urandom_range(127, 1)), 16'd2,
                          4'($urandom), 7'($urandom)));
    end
    run_random(PHASE_ITEMS);
    in_valid <= 1'b0;

    // Let every expected event arrive, then look for strays.
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d note starts (%0d untracked) and %0d ticks,",
             sb.starts_seen, sb.untracked_starts, sb.ticks_seen);
    $display("checking %0d key-on and %0d key-off events; %0d mismatches.",
             sb.key_ons_checked, sb.key_offs_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
